>>> hdl/z80alu_pkg.sv
// ----------------------------------------------------------------------------
// z80alu_pkg
// Shared types, command codes and flag bit positions for the Z80 style ALU.
// ----------------------------------------------------------------------------
package z80alu_pkg;

	typedef logic [4:0] cmd_t;

	localparam cmd_t CMD_ADD  = 5'd0;
	localparam cmd_t CMD_ADC  = 5'd1;
	localparam cmd_t CMD_SUB  = 5'd2;
	localparam cmd_t CMD_SBC  = 5'd3;
	localparam cmd_t CMD_CP   = 5'd4;
	localparam cmd_t CMD_AND  = 5'd5;
	localparam cmd_t CMD_OR   = 5'd6;
	localparam cmd_t CMD_XOR  = 5'd7;
	localparam cmd_t CMD_INC  = 5'd8;
	localparam cmd_t CMD_DEC  = 5'd9;
	localparam cmd_t CMD_RLC  = 5'd10;
	localparam cmd_t CMD_RRC  = 5'd11;
	localparam cmd_t CMD_RL   = 5'd12;
	localparam cmd_t CMD_RR   = 5'd13;
	localparam cmd_t CMD_SLA  = 5'd14;
	localparam cmd_t CMD_SRA  = 5'd15;
	localparam cmd_t CMD_SLL  = 5'd16;
	localparam cmd_t CMD_SRL  = 5'd17;
	localparam cmd_t CMD_BIT  = 5'd18;
	localparam cmd_t CMD_SET  = 5'd19;
	localparam cmd_t CMD_RES  = 5'd20;
	localparam cmd_t CMD_CPL  = 5'd21;
	localparam cmd_t CMD_SCF  = 5'd22;
	localparam cmd_t CMD_CCF  = 5'd23;
	localparam cmd_t CMD_RLCA = 5'd24;
	localparam cmd_t CMD_RRCA = 5'd25;
	localparam cmd_t CMD_RLA  = 5'd26;
	localparam cmd_t CMD_RRA  = 5'd27;

	// Flag byte layout: S Z Y H X PV N C
	localparam int FL_S = 7;
	localparam int FL_Z = 6;
	localparam int FL_Y = 5;
	localparam int FL_H = 4;
	localparam int FL_X = 3;
	localparam int FL_P = 2;
	localparam int FL_N = 1;
	localparam int FL_C = 0;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
		logic [2:0] bit_index;
		logic [7:0] flags_in;
	} alu_in_t;

	typedef struct packed {
		logic [7:0] result;
		logic [7:0] flags_out;
	} alu_out_t;

endpackage

>>> hdl/z80alu_core.sv
// ----------------------------------------------------------------------------
// z80alu_core
// Combinational datapath: result byte and new flag byte for one command word.
// ----------------------------------------------------------------------------
module z80alu_core
	import z80alu_pkg::*;
(
	input  alu_in_t  in_word,
	output alu_out_t out_word
);

	// Sign, zero and the two undocumented copy bits taken from a result byte.
	function automatic logic [7:0] szyx(input logic [7:0] v);
		logic [7:0] f;
		begin
			f = 8'h00;
			f[FL_S] = v[7];
			f[FL_Z] = (v == 8'h00);
			f[FL_Y] = v[5];
			f[FL_X] = v[3];
			return f;
		end
	endfunction

	cmd_t       cmd;
	logic [7:0] a;
	logic [7:0] b;
	logic [2:0] bi;
	logic [7:0] fi;
	logic       cin;
	logic [8:0] add9;
	logic [8:0] sub9;
	logic [7:0] inc8;
	logic [7:0] dec8;
	logic [7:0] bit_mask;
	logic [7:0] rot_r;
	logic       rot_c;
	logic [7:0] r;
	logic [7:0] f;

	assign cmd = in_word.command;
	assign a   = in_word.operand_a;
	assign b   = in_word.operand_b;
	assign bi  = in_word.bit_index;
	assign fi  = in_word.flags_in;
	assign cin = fi[FL_C];

	assign add9     = {1'b0, a} + {1'b0, b} + {8'd0, (cmd == CMD_ADC) & cin};
	assign sub9     = {1'b0, a} - {1'b0, b} - {8'd0, (cmd == CMD_SBC) & cin};
	assign inc8     = a + 8'd1;
	assign dec8     = a - 8'd1;
	assign bit_mask = 8'd1 << bi;

	// The accumulator rotates share the shifter with their CB prefixed forms.
	always_comb begin
		case (cmd)
			CMD_RLC, CMD_RLCA: begin
				rot_c = a[7];
				rot_r = {a[6:0], a[7]};
			end
			CMD_RRC, CMD_RRCA: begin
				rot_c = a[0];
				rot_r = {a[0], a[7:1]};
			end
			CMD_RL, CMD_RLA: begin
				rot_c = a[7];
				rot_r = {a[6:0], cin};
			end
			CMD_RR, CMD_RRA: begin
				rot_c = a[0];
				rot_r = {cin, a[7:1]};
			end
			CMD_SLA: begin
				rot_c = a[7];
				rot_r = {a[6:0], 1'b0};
			end
			CMD_SRA: begin
				rot_c = a[0];
				rot_r = {a[7], a[7:1]};
			end
			CMD_SLL: begin
				rot_c = a[7];
				rot_r = {a[6:0], 1'b1};
			end
			CMD_SRL: begin
				rot_c = a[0];
				rot_r = {1'b0, a[7:1]};
			end
			default: begin
				rot_c = 1'b0;
				rot_r = a;
			end
		endcase
	end

	always_comb begin
		r = a;
		f = fi;
		case (cmd)
			CMD_ADD, CMD_ADC: begin
				r       = add9[7:0];
				f       = szyx(add9[7:0]);
				f[FL_H] = a[4] ^ b[4] ^ add9[4];
				f[FL_P] = ~(a[7] ^ b[7]) & (a[7] ^ add9[7]);
				f[FL_C] = add9[8];
			end
			CMD_SUB, CMD_SBC, CMD_CP: begin
				r       = sub9[7:0];
				f       = szyx(sub9[7:0]);
				f[FL_H] = a[4] ^ b[4] ^ sub9[4];
				f[FL_P] = (a[7] ^ b[7]) & (a[7] ^ sub9[7]);
				f[FL_N] = 1'b1;
				f[FL_C] = sub9[8];
				if (cmd == CMD_CP) begin
					// Compare keeps the accumulator and copies Y and X from the operand.
					r       = a;
					f[FL_Y] = b[5];
					f[FL_X] = b[3];
				end
			end
			CMD_AND, CMD_OR, CMD_XOR: begin
				if (cmd == CMD_AND) begin
					r = a & b;
				end else if (cmd == CMD_OR) begin
					r = a | b;
				end else begin
					r = a ^ b;
				end
				f       = szyx(r);
				f[FL_P] = ~^r;
				f[FL_H] = (cmd == CMD_AND);
			end
			CMD_INC: begin
				r       = inc8;
				f       = szyx(inc8);
				f[FL_C] = cin;
				f[FL_P] = (inc8 == 8'h80);
				f[FL_H] = (inc8[3:0] == 4'h0);
			end
			CMD_DEC: begin
				r       = dec8;
				f       = szyx(dec8);
				f[FL_C] = cin;
				f[FL_N] = 1'b1;
				f[FL_P] = (dec8 == 8'h7f);
				f[FL_H] = (dec8[3:0] == 4'hf);
			end
			CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA, CMD_SLL, CMD_SRL: begin
				r       = rot_r;
				f       = szyx(rot_r);
				f[FL_P] = ~^rot_r;
				f[FL_C] = rot_c;
			end
			CMD_RLCA, CMD_RRCA, CMD_RLA, CMD_RRA: begin
				// S, Z and PV are left as they were.
				r       = rot_r;
				f[FL_Y] = rot_r[5];
				f[FL_H] = 1'b0;
				f[FL_X] = rot_r[3];
				f[FL_N] = 1'b0;
				f[FL_C] = rot_c;
			end
			CMD_BIT: begin
				f       = 8'h00;
				f[FL_S] = (bi == 3'd7) & a[7];
				f[FL_Z] = ~|(a & bit_mask);
				f[FL_Y] = a[5];
				f[FL_H] = 1'b1;
				f[FL_X] = a[3];
				f[FL_P] = ~|(a & bit_mask);
				f[FL_C] = cin;
			end
			CMD_SET: begin
				r = a | bit_mask;
			end
			CMD_RES: begin
				r = a & ~bit_mask;
			end
			CMD_CPL: begin
				r       = ~a;
				f[FL_Y] = ~a[5];
				f[FL_X] = ~a[3];
				f[FL_H] = 1'b1;
				f[FL_N] = 1'b1;
			end
			CMD_SCF: begin
				f[FL_H] = 1'b0;
				f[FL_N] = 1'b0;
				f[FL_C] = 1'b1;
			end
			CMD_CCF: begin
				f[FL_H] = cin;
				f[FL_N] = 1'b0;
				f[FL_C] = ~cin;
			end
			default: begin
				r = a;
				f = fi;
			end
		endcase
	end

	assign out_word.result    = r;
	assign out_word.flags_out = f;

endmodule

>>> hdl/z80_alu_with_flags_unit.sv
// ----------------------------------------------------------------------------
// z80_alu_with_flags_unit
// Z80 style 8-bit ALU with flag generation, registered at input and output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_word and raise start. The word is taken at the
//   rising edge where start is high and busy is low. busy is always low, so a
//   new word may be given in every cycle.
//   Output channel: done is high for exactly one cycle with the result byte
//   and the new flag byte on out_word. The receiver must take it in that
//   cycle; there is no way to hold results back, and none is needed.
//   Pipeline: a word is taken into the input register, and done rises when
//   its result is taken into the result register; nothing can stall between.
//   Throughput: one word per cycle, since all the arithmetic and flag logic
//   sits in one combinational pass between those two registers.
//   Reset: arst_n low clears both valid flags at once; no words are pending
//   afterwards. The input and result data registers are not reset.
// ----------------------------------------------------------------------------
module z80_alu_with_flags_unit
	import z80alu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  alu_in_t  in_word,
	output logic     done,
	output alu_out_t out_word
);

	logic     valid_s1;
	alu_in_t  in_s1;
	logic     valid_s2;
	alu_out_t out_s2;
	alu_out_t core_out;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			in_s1 <= in_word;
		end
		if (valid_s1) begin
			out_s2 <= core_out;
		end
	end

	z80alu_core u_core (
		.in_word  (in_s1),
		.out_word (core_out)
	);

	assign done     = valid_s2;
	assign out_word = out_s2;

endmodule

>>> hdl/z80alu_checker.sv
// ----------------------------------------------------------------------------
// z80alu_checker
// Port level checks on timing and on commands that pass values through.
// ----------------------------------------------------------------------------
module z80alu_checker
	import z80alu_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input alu_in_t  in_word,
	input logic     done,
	input alu_out_t out_word
);

	// Every accepted word comes out on done once it has passed both registers.
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted word produced no result");

	// A result never appears without a matching accepted word.
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted word");

	// Compare leaves the accumulator untouched.
	a_cp_keeps_a: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(in_word.command, 2) == CMD_CP)
		|-> out_word.result == $past(in_word.operand_a, 2))
		else $error("compare altered the accumulator");

	// Unknown codes, SET and RES leave the flag byte as it came in.
	a_flags_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(in_word.command, 2) > CMD_RRA
			|| $past(in_word.command, 2) == CMD_SET
			|| $past(in_word.command, 2) == CMD_RES))
		|-> out_word.flags_out == $past(in_word.flags_in, 2))
		else $error("flags changed by a command that must keep them");

endmodule

bind z80_alu_with_flags_unit z80alu_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.in_word  (in_word),
	.done     (done),
	.out_word (out_word)
);

>>> dv/z80_alu_with_flags_unit_test.sv
// ----------------------------------------------------------------------------
// z80_alu_with_flags_unit_test
// Self-checking bench for the Z80 style ALU. Every accepted command word is
// run through a behavioural model of the result byte and the flag byte, and
// each done word is compared with the oldest prediction. A directed pass
// covers every command code and the flag corner cases. A long random pass
// with bursts and random gaps follows it.
// ----------------------------------------------------------------------------
module z80_alu_with_flags_unit_test
	import z80alu_pkg::*;
();

	localparam int   GAP_MAX      = 11;
	localparam int   RANDOM_WORDS = 2000;
	localparam int   IDLE_LIMIT   = 500;
	localparam int   DRAIN_CYCLES = 8;
	localparam cmd_t CMD_TOP      = '1;

	class alu_result_board;
		alu_out_t pending_results[$];
		int       words_in;
		int       results_seen;
		int       mismatches;

		static function logic [7:0] sign_zero_yx(logic [7:0] r);
			logic [7:0] f;
			f        = '0;
			f[FL_S]  = r[FL_S];
			f[FL_Z]  = (r == 8'h00);
			f[FL_Y]  = r[FL_Y];
			f[FL_X]  = r[FL_X];
			return f;
		endfunction

		static function alu_out_t z80_alu_result(alu_in_t w);
			logic [7:0] a, b, r, f;
			logic [8:0] z;
			logic       cin, co;
			alu_out_t   o;
			a   = w.operand_a;
			b   = w.operand_b;
			f   = w.flags_in;
			cin = f[FL_C];
			r   = a;
			co  = 1'b0;
			case (w.command)
				CMD_ADD, CMD_ADC: begin
					z = {1'b0, a} + {1'b0, b} + {8'd0, (w.command == CMD_ADC) & cin};
					r = z[7:0];
					f = sign_zero_yx(r);
					f[FL_H] = a[4] ^ b[4] ^ z[4];
					f[FL_C] = z[8];
					f[FL_P] = (a[7] == b[7]) && (a[7] != z[7]);
				end
				CMD_SUB, CMD_SBC, CMD_CP: begin
					z = {1'b0, a} - {1'b0, b} - {8'd0, (w.command == CMD_SBC) & cin};
					r = z[7:0];
					f = sign_zero_yx(r);
					f[FL_H] = a[4] ^ b[4] ^ z[4];
					f[FL_N] = 1'b1;
					f[FL_C] = z[8];
					f[FL_P] = (a[7] != b[7]) && (a[7] != z[7]);
					// Compare keeps the accumulator and takes Y and X from the operand.
					if (w.command == CMD_CP) begin
						f[FL_Y] = b[FL_Y];
						f[FL_X] = b[FL_X];
						r = a;
					end
				end
				CMD_AND, CMD_OR, CMD_XOR: begin
					r = (w.command == CMD_AND) ? (a & b) :
					    (w.command == CMD_OR)  ? (a | b) : (a ^ b);
					f = sign_zero_yx(r);
					f[FL_P] = ~^r;
					f[FL_H] = (w.command == CMD_AND);
				end
				CMD_INC: begin
					r = a + 8'd1;
					f = sign_zero_yx(r);
					f[FL_C] = cin;
					f[FL_P] = (r == 8'h80);
					f[FL_H] = (r[3:0] == 4'h0);
				end
				CMD_DEC: begin
					r = a - 8'd1;
					f = sign_zero_yx(r);
					f[FL_C] = cin;
					f[FL_N] = 1'b1;
					f[FL_P] = (r == 8'h7f);
					f[FL_H] = (r[3:0] == 4'hf);
				end
				CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA, CMD_SLL, CMD_SRL,
				CMD_RLCA, CMD_RRCA, CMD_RLA, CMD_RRA: begin
					case (w.command)
						CMD_RLC, CMD_RLCA: {co, r} = {a[7], a[6:0], a[7]};
						CMD_RRC, CMD_RRCA: {co, r} = {a[0], a[0], a[7:1]};
						CMD_RL, CMD_RLA:   {co, r} = {a[7], a[6:0], cin};
						CMD_RR, CMD_RRA:   {co, r} = {a[0], cin, a[7:1]};
						CMD_SLA:           {co, r} = {a[7], a[6:0], 1'b0};
						CMD_SRA:           {co, r} = {a[0], a[7], a[7:1]};
						CMD_SLL:           {co, r} = {a[7], a[6:0], 1'b1};
						default:           {co, r} = {a[0], 1'b0, a[7:1]};
					endcase
					// The accumulator forms leave S, Z and PV as they were.
					if (w.command >= CMD_RLCA) begin
						f[FL_Y] = r[FL_Y];
						f[FL_X] = r[FL_X];
						f[FL_H] = 1'b0;
						f[FL_N] = 1'b0;
					end else begin
						f = sign_zero_yx(r);
						f[FL_P] = ~^r;
					end
					f[FL_C] = co;
				end
				CMD_BIT: begin
					f = '0;
					f[FL_C] = cin;
					f[FL_H] = 1'b1;
					f[FL_Y] = a[FL_Y];
					f[FL_X] = a[FL_X];
					if (!a[w.bit_index]) begin
						f[FL_Z] = 1'b1;
						f[FL_P] = 1'b1;
					end else if (w.bit_index == 3'd7) begin
						f[FL_S] = 1'b1;
					end
				end
				CMD_SET: r = a | (8'd1 << w.bit_index);
				CMD_RES: r = a & ~(8'd1 << w.bit_index);
				CMD_CPL: begin
					r = ~a;
					f[FL_Y] = r[FL_Y];
					f[FL_X] = r[FL_X];
					f[FL_H] = 1'b1;
					f[FL_N] = 1'b1;
				end
				CMD_SCF: begin
					f[FL_H] = 1'b0;
					f[FL_N] = 1'b0;
					f[FL_C] = 1'b1;
				end
				CMD_CCF: begin
					f[FL_H] = cin;
					f[FL_N] = 1'b0;
					f[FL_C] = ~cin;
				end
				default: ;
			endcase
			o.result    = r;
			o.flags_out = f;
			return o;
		endfunction

		function void note_word(alu_in_t w);
			pending_results.push_back(z80_alu_result(w));
			words_in++;
		endfunction

		function void check_word(alu_out_t got);
			alu_out_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result word: result %02h flags_out %02h",
				       got.result, got.flags_out);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got.result !== want.result) begin
				$error("result: expected %02h, actual %02h", want.result, got.result);
				mismatches++;
			end
			if (got.flags_out !== want.flags_out) begin
				$error("flags_out: expected %08b, actual %08b", want.flags_out, got.flags_out);
				mismatches++;
			end
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	alu_in_t  in_word = '0;
	logic     done;
	alu_out_t out_word;

	alu_result_board board = new();
	int              idle_cycles = 0;
	int              burst_left = 0;

	always #1 clk = ~clk;

	z80_alu_with_flags_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.in_word  (in_word),
		.done     (done),
		.out_word (out_word)
	);

	// Values read here are the ones present just before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_word(in_word);
			if (done)
				board.check_word(out_word);
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: nothing moved for %0d cycles.", IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick_byte();
		logic [7:0] corner_bytes[8];
		corner_bytes = '{8'h00, 8'hff, 8'h7f, 8'h80, 8'h01, 8'h0f, 8'h10, 8'hfe};
		if ($urandom_range(0, 3) == 0)
			return corner_bytes[$urandom_range(0, 7)];
		return 8'($urandom);
	endfunction

	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			burst_left = $urandom_range(10, 40);
		return $urandom_range(0, GAP_MAX);
	endfunction

	// A word is held on the inputs until an edge finds busy low.
	task automatic send_word(input alu_in_t w);
		int gap;
		bit taken;
		gap = next_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		in_word <= w;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_fields(input cmd_t c, input logic [7:0] a, input logic [7:0] b,
	                           input logic [2:0] bi, input logic [7:0] fl);
		alu_in_t w;
		w.command   = c;
		w.operand_a = a;
		w.operand_b = b;
		w.bit_index = bi;
		w.flags_in  = fl;
		send_word(w);
	endtask

	initial begin
		alu_in_t w;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every command code, undefined ones included, with extreme operands.
		for (int i = 0; i <= int'(CMD_TOP); i++)
			send_fields(cmd_t'(i), (i % 2) ? 8'hff : 8'h00, (i % 3) ? 8'h80 : 8'h7f,
			            3'(i), (i % 2) ? 8'h00 : 8'hff);
		// Overflow, half carry and carry corners.
		send_fields(CMD_ADD, 8'h7f, 8'h01, 3'd0, 8'h00);
		send_fields(CMD_ADC, 8'hff, 8'h00, 3'd0, 8'h01);
		send_fields(CMD_SUB, 8'h80, 8'h01, 3'd0, 8'hff);
		send_fields(CMD_SBC, 8'h00, 8'hff, 3'd0, 8'h01);
		send_fields(CMD_CP,  8'h55, 8'h28, 3'd0, 8'h00);
		send_fields(CMD_INC, 8'h7f, 8'h00, 3'd0, 8'h01);
		send_fields(CMD_DEC, 8'h80, 8'h00, 3'd0, 8'h00);
		send_fields(CMD_BIT, 8'h80, 8'h00, 3'd7, 8'h00);
		send_fields(CMD_CCF, 8'h00, 8'h00, 3'd0, 8'h01);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if ($urandom_range(0, 15) == 0)
				w.command = cmd_t'($urandom_range(int'(CMD_RRA) + 1, int'(CMD_TOP)));
			else
				w.command = cmd_t'($urandom_range(int'(CMD_ADD), int'(CMD_RRA)));
			w.operand_a = pick_byte();
			w.operand_b = pick_byte();
			w.bit_index = 3'($urandom);
			w.flags_in  = ($urandom_range(0, 7) == 0) ? pick_byte() : 8'($urandom);
			send_word(w);
		end
		start <= 1'b0;

		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d command words over all 32 command codes; %0d results checked.",
		         board.words_in, board.results_seen);
		$display("Mismatches: %0d, predictions left unanswered: %0d.",
		         board.mismatches, board.pending_results.size());
		if (board.mismatches == 0 && board.pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
